### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the link packet checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clock, reset, lhs, rhs, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clock, reset, lhs, rhs, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

### rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// Link packet checker package
// Beat types, verdict codes, register indexes and hash constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  localparam int MAX_MESSAGE_BYTES = 256;

  localparam int COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;
  localparam logic [COUNT_W-1:0] HDR_BYTES  = 10'd8;
  localparam logic [COUNT_W-1:0] CSUM_BYTES = 10'd4;
  localparam logic [COUNT_W-1:0] LIMIT_CAP  = COUNT_W'(MAX_MESSAGE_BYTES);

  localparam logic [31:0] HASH_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROLE_IS_HOST = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SELF_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOST_ADDRESS = 2'd2;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SIZE         = 3'd1,
    ST_CHECKSUM     = 3'd2,
    ST_BAD_PAIR     = 3'd3,
    ST_WRONG_RX     = 3'd4,
    ST_WRONG_SENDER = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] expected_sender;
    logic [8:0] max_message;
  } byte_beat_t;

  typedef struct packed {
    status_t     status;
    logic        retry;
    logic [15:0] message_length;
    logic [7:0]  sender;
    logic [7:0]  receiver;
  } verdict_t;

endpackage

`default_nettype wire

### rtl/link_packet_checker.sv
// ----------------------------------------------------------------------------
// Link packet checker
// Checks one framed link packet byte by byte and gives one verdict per packet.
// ----------------------------------------------------------------------------
// The byte channel (byte_valid, byte_stall, byte_beat) carries one packet
// byte per beat, with last_byte marking the final byte of a packet. The
// verdict channel (verdict_valid, verdict_stall, verdict_beat) carries one
// beat per packet, giving the status, the retry flag and the length, sender and receiver fields.
// The configuration port (cfg_write, cfg_index, cfg_data) writes the role,
// the own address and the host address; writes take effect at once.
// Every byte is taken as it arrives unless byte_stall is high, so the block
// sustains one byte per cycle while not stalled. The hash update, one xor and
// one constant multiply, is done as the byte is taken. The final byte loads
// an evaluation register, and the status is formed from it into the output
// register, which takes it once that register is free.
// When the receiver stalls, the output register holds its beat and the
// evaluation register may still take one more packet end; byte_stall rises
// only while both are full. Synchronous reset clears the packet state, the
// registers to their reset values, and both pipeline stages to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module link_packet_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            byte_valid,
  output logic                                 byte_stall,
  input  wire lpc_pkg::byte_beat_t             byte_beat,
  output logic                                 verdict_valid,
  input  wire logic                            verdict_stall,
  output lpc_pkg::verdict_t                    verdict_beat,
  input  wire logic                            cfg_write,
  input  wire logic [lpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpc_pkg::*;

  logic       role_is_host;
  logic [6:0] self_address;
  logic [7:0] host_address;

  logic [COUNT_W-1:0] byte_count;
  logic [31:0]        running_hash;
  logic [31:0]        header_checksum;
  logic [15:0]        header_length;
  logic [7:0]         header_sender;
  logic [7:0]         header_receiver;

  logic [COUNT_W-1:0] byte_count_next;
  logic [31:0]        running_hash_next;
  logic [31:0]        header_checksum_next;
  logic [15:0]        header_length_next;
  logic [7:0]         header_sender_next;
  logic [7:0]         header_receiver_next;

  logic               eval_valid;
  logic [COUNT_W-1:0] eval_count;
  logic [31:0]        eval_hash;
  logic [31:0]        eval_checksum;
  logic [15:0]        eval_length;
  logic [7:0]         eval_sender;
  logic [7:0]         eval_receiver;
  logic [7:0]         eval_expected;
  logic [8:0]         eval_max;

  logic               accept;
  logic               out_free;
  logic               eval_move;
  logic [31:0]        hash_mixed;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] msg;
  logic [7:0]         me;
  status_t            status;

  assign out_free   = !verdict_valid || !verdict_stall;
  assign eval_move  = eval_valid && out_free;
  assign byte_stall = eval_valid && !out_free;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    hash_mixed           = running_hash ^ {24'b0, byte_beat.data_byte};
    running_hash_next    = running_hash;
    header_checksum_next = header_checksum;
    header_length_next   = header_length;
    header_sender_next   = header_sender;
    header_receiver_next = header_receiver;
    if (byte_count < CSUM_BYTES) begin
      header_checksum_next = header_checksum |
          (32'(byte_beat.data_byte) << {byte_count[1:0], 3'b000});
    end else begin
      running_hash_next = hash_mixed * HASH_PRIME;
      unique case (byte_count)
        10'd4:   header_length_next = {header_length[15:8], byte_beat.data_byte};
        10'd5:   header_length_next = {byte_beat.data_byte, header_length[7:0]};
        10'd6:   header_sender_next = byte_beat.data_byte;
        10'd7:   header_receiver_next = byte_beat.data_byte;
        default: header_length_next = header_length;
      endcase
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 10'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      role_is_host <= 1'b0;
      self_address <= 7'd8;
      host_address <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROLE_IS_HOST: role_is_host <= cfg_data[0];
        CFG_SELF_ADDRESS: self_address <= cfg_data[6:0];
        CFG_HOST_ADDRESS: host_address <= cfg_data;
        default:          role_is_host <= role_is_host;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_hash    <= HASH_BASIS;
      header_checksum <= '0;
      header_length   <= '0;
      header_sender   <= '0;
      header_receiver <= '0;
    end else if (accept) begin
      if (byte_beat.last_byte) begin
        byte_count      <= '0;
        running_hash    <= HASH_BASIS;
        header_checksum <= '0;
        header_length   <= '0;
        header_sender   <= '0;
        header_receiver <= '0;
      end else begin
        byte_count      <= byte_count_next;
        running_hash    <= running_hash_next;
        header_checksum <= header_checksum_next;
        header_length   <= header_length_next;
        header_sender   <= header_sender_next;
        header_receiver <= header_receiver_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else if (accept && byte_beat.last_byte) begin
      eval_valid <= 1'b1;
    end else if (eval_move) begin
      eval_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_beat.last_byte) begin
      eval_count    <= byte_count_next;
      eval_hash     <= running_hash_next;
      eval_checksum <= header_checksum_next;
      eval_length   <= header_length_next;
      eval_sender   <= header_sender_next;
      eval_receiver <= header_receiver_next;
      eval_expected <= byte_beat.expected_sender;
      eval_max      <= byte_beat.max_message;
    end
  end

  always_comb begin
    limit = ({1'b0, eval_max} > LIMIT_CAP) ? LIMIT_CAP : {1'b0, eval_max};
    msg   = eval_count - HDR_BYTES;
    me    = role_is_host ? host_address : {1'b0, self_address};
    priority if (eval_count < HDR_BYTES) begin
      status = ST_SIZE;
    end else if (eval_count == COUNT_MAX || msg > limit ||
                 {6'b0, msg} != eval_length) begin
      status = ST_SIZE;
    end else if (eval_hash != eval_checksum) begin
      status = ST_CHECKSUM;
    end else if ((eval_sender == host_address) == (eval_receiver == host_address)) begin
      status = ST_BAD_PAIR;
    end else if (eval_receiver != me) begin
      status = role_is_host ? ST_BAD_PAIR : ST_WRONG_RX;
    end else if (eval_sender != eval_expected) begin
      status = role_is_host ? ST_WRONG_SENDER : ST_BAD_PAIR;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (eval_move) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_move) begin
      verdict_beat.status         <= status;
      verdict_beat.retry          <= (status == ST_SIZE) || (status == ST_CHECKSUM) ||
                                     (status == ST_WRONG_RX);
      verdict_beat.message_length <= eval_length;
      verdict_beat.sender         <= eval_sender;
      verdict_beat.receiver       <= eval_receiver;
    end
  end

endmodule

`default_nettype wire

### rtl/lpc_checker.sv
// ----------------------------------------------------------------------------
// Link packet checker port checks
// Concurrent checks on the ports of the link packet checker, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            byte_valid,
  input wire logic                            byte_stall,
  input wire lpc_pkg::byte_beat_t             byte_beat,
  input wire logic                            verdict_valid,
  input wire logic                            verdict_stall,
  input wire lpc_pkg::verdict_t               verdict_beat
);
  import lpc_pkg::*;

  logic last_taken;

  assign last_taken = byte_valid && !byte_stall && byte_beat.last_byte;

  `ASSERT_NEXT(a_verdict_held, clk, rst, verdict_valid && verdict_stall,
    verdict_valid, "verdict beat dropped while stalled")

  `ASSERT_IMPLIES(a_retry_code, clk, rst, verdict_valid,
    verdict_beat.retry == ((verdict_beat.status == ST_SIZE) ||
    (verdict_beat.status == ST_CHECKSUM) || (verdict_beat.status == ST_WRONG_RX)),
    "retry flag disagrees with status")

  `ASSERT_IMPLIES(a_verdict_source, clk, rst, $rose(verdict_valid),
    $past(last_taken, 2), "verdict without a last byte two cycles before")

  `ASSERT_IMPLIES(a_stall_cause, clk, rst, byte_stall,
    verdict_valid && verdict_stall, "byte stall without a stalled verdict")

endmodule

bind link_packet_checker lpc_checker u_lpc_checker (.*);

`default_nettype wire
